@@ rtl/mcls_pkg.sv @@
package mcls_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam logic [31:0] INV_CELL_WIDTH_RESET = 32'd65536;
   localparam int SAMPLE_W = 32;
   localparam int DIFF_W = 33;
   localparam int MAG_W = 33;

   typedef struct packed {
      logic        valid;
      logic        d_neg;
      logic        r_neg;
      logic        n_zero;
      logic        d_zero;
      logic [MAG_W-1:0] n_mag;
      logic [MAG_W-1:0] d_mag;
   } diff_type;
endpackage

@@ rtl/mc_limited_slope_top.sv @@
// MC slope limiter, fully pipelined: one stencil request accepted per cycle;
// a skid register behind the output register lets a new request enter while a
// result waits, and the whole pipe freezes only once the skid register is also
// full.
module mc_limited_slope_top
   import mcls_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sample_ahead, sample_centre, sample_behind, sample_far
   input  logic [127:0] req_tdata,
   // velocity_negative
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // slope_value, limiter_value, ratio_clamped, zero fill
   output logic [55:0]  rsp_tdata
);
   localparam int LW = FRAC_BITS + 2;
   localparam int QW = FRAC_BITS + 3;
   localparam logic [QW-1:0] R_MAX = QW'(4) << FRAC_BITS;
   localparam logic [LW-1:0] TWO = LW'(2) << FRAC_BITS;
   localparam logic [LW-1:0] ONE = LW'(1) << FRAC_BITS;

   logic [31:0] icw_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) icw_ff <= INV_CELL_WIDTH_RESET;
      else if (csr_valid) icw_ff <= csr_data;
   end

   logic advance, out_full_ff, skid_full_ff;
   assign advance    = !skid_full_ff;
   assign req_tready = advance;

   // stage 1: differences and magnitudes
   logic signed [DIFF_W-1:0] d_s, n_s;
   diff_type diff_ff;
   always_comb begin
      logic signed [31:0] a, c, b, f;
      a = req_tdata[31:0];
      c = req_tdata[63:32];
      b = req_tdata[95:64];
      f = req_tdata[127:96];
      d_s = DIFF_W'(c) - DIFF_W'(b);
      n_s = req_tuser ? DIFF_W'(a) - DIFF_W'(c) : DIFF_W'(b) - DIFF_W'(f);
   end
   always_ff @(posedge clock) begin
      if (reset) diff_ff.valid <= 1'b0;
      else if (advance) diff_ff.valid <= req_tvalid && req_tready;
      if (advance) begin
         diff_ff.d_neg  <= d_s[DIFF_W-1];
         diff_ff.r_neg  <= n_s[DIFF_W-1] != d_s[DIFF_W-1];
         diff_ff.n_zero <= n_s == '0;
         diff_ff.d_zero <= d_s == '0;
         diff_ff.n_mag  <= n_s[DIFF_W-1] ? MAG_W'(-n_s) : MAG_W'(n_s);
         diff_ff.d_mag  <= d_s[DIFF_W-1] ? MAG_W'(-d_s) : MAG_W'(d_s);
      end
   end

   logic dv_valid, dv_over;
   logic [QW-1:0] dv_q;
   logic [MAG_W-1:0] dv_d;
   logic [3:0] dv_tag;
   mcls_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(diff_ff.valid), .numer(diff_ff.n_mag), .denom(diff_ff.d_mag),
      .tag_in({diff_ff.d_neg, diff_ff.r_neg, diff_ff.n_zero, diff_ff.d_zero}),
      .out_valid(dv_valid), .quot(dv_q), .over(dv_over),
      .denom_out(dv_d), .tag_out(dv_tag)
   );

   // stage: limiter
   logic lim_valid_ff, lim_dneg_ff, lim_clamp_ff;
   logic [LW-1:0] phi_ff;
   logic [MAG_W-1:0] lim_d_ff;
   logic [QW-1:0] q_sat;
   logic clamp_c, rpos;
   logic [LW-1:0] phi_c, half_c;
   logic [QW:0] two_r;
   always_comb begin
      if (dv_tag[0]) begin
         q_sat   = dv_tag[1] ? '0 : R_MAX;
         clamp_c = 1'b1;
      end else if (dv_over || dv_q > R_MAX) begin
         q_sat   = R_MAX;
         clamp_c = 1'b1;
      end else begin
         q_sat   = dv_q;
         clamp_c = 1'b0;
      end
      // with d zero the sign follows n alone: d_neg is 0 then
      rpos   = (q_sat != '0) && !dv_tag[2];
      half_c = LW'(({1'b0, q_sat} + (QW+1)'(ONE)) >> 1);
      two_r  = {q_sat, 1'b0};
      phi_c  = half_c;
      if (phi_c > TWO) phi_c = TWO;
      if ((QW+1)'(phi_c) > two_r) phi_c = LW'(two_r);
      if (!rpos) phi_c = '0;
   end
   always_ff @(posedge clock) begin
      if (reset) lim_valid_ff <= 1'b0;
      else if (advance) lim_valid_ff <= dv_valid;
      if (advance) begin
         phi_ff       <= phi_c;
         lim_clamp_ff <= clamp_c;
         lim_dneg_ff  <= dv_tag[3];
         lim_d_ff     <= dv_d;
      end
   end

   // stage: t = phi*|d| >> F  (t fits 34 bits)
   logic t_valid_ff, t_dneg_ff, t_clamp_ff;
   logic [LW-1:0] t_phi_ff;
   logic [MAG_W:0] t_ff;
   logic [MAG_W+LW-1:0] prod_t;
   assign prod_t = (MAG_W+LW)'(phi_ff) * (MAG_W+LW)'(lim_d_ff);
   always_ff @(posedge clock) begin
      if (reset) t_valid_ff <= 1'b0;
      else if (advance) t_valid_ff <= lim_valid_ff;
      if (advance) begin
         t_ff       <= (MAG_W+1)'(prod_t >> FRAC_BITS);
         t_phi_ff   <= phi_ff;
         t_dneg_ff  <= lim_dneg_ff;
         t_clamp_ff <= lim_clamp_ff;
      end
   end

   // stage: partial products with register halves
   logic p_valid_ff, p_dneg_ff, p_clamp_ff;
   logic [LW-1:0] p_phi_ff;
   logic [MAG_W+16:0] hi_ff, lo_ff;
   always_ff @(posedge clock) begin
      if (reset) p_valid_ff <= 1'b0;
      else if (advance) p_valid_ff <= t_valid_ff;
      if (advance) begin
         hi_ff      <= (MAG_W+17)'(t_ff) * (MAG_W+17)'(icw_ff[31:16]);
         lo_ff      <= (MAG_W+17)'(t_ff) * (MAG_W+17)'(icw_ff[15:0]);
         p_phi_ff   <= t_phi_ff;
         p_dneg_ff  <= t_dneg_ff;
         p_clamp_ff <= t_clamp_ff;
      end
   end

   // stage: combine, saturate, sign
   logic [MAG_W+33:0] sum_c;
   logic [MAG_W+33:0] mag_c;
   logic [31:0] slope_c;
   always_comb begin
      sum_c = ((MAG_W+34)'(hi_ff) << 16) + (MAG_W+34)'(lo_ff);
      mag_c = sum_c >> FRAC_BITS;
      if (p_dneg_ff) begin
         slope_c = (mag_c >= (MAG_W+34)'(33'h80000000)) ? 32'h80000000
                   : 32'(~mag_c + 1'b1);
      end else begin
         slope_c = (mag_c > (MAG_W+34)'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : mag_c[31:0];
      end
   end

   // output register with one skid entry behind it
   logic [55:0] result_c;
   logic [55:0] skid_data_ff;
   assign result_c = 56'({p_clamp_ff, 18'(p_phi_ff), slope_c});

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff  <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_tready) skid_full_ff <= 1'b0;
      end else if (out_full_ff && !rsp_tready) begin
         skid_full_ff <= p_valid_ff;
      end else begin
         out_full_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (rsp_tready) rsp_tdata <= skid_data_ff;
      end else if (out_full_ff && !rsp_tready) begin
         skid_data_ff <= result_c;
      end else begin
         rsp_tdata <= result_c;
      end
   end
   assign rsp_tvalid = out_full_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && rsp_tvalid)
      else $error("result changed while stalled");
   a_skid: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_tvalid)
      else $error("skid entry held without a result");
   a_phi: assert property (@(posedge clock) disable iff (reset)
      lim_valid_ff |-> phi_ff <= TWO)
      else $error("limiter above two");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      dv_valid && dv_tag[0] |-> clamp_c)
      else $error("zero denominator not flagged");
endmodule

@@ rtl/mcls_divider.sv @@
// pipelined restoring divider: one quotient bit per stage; a quotient below
// 8.0 needs only FRAC_BITS+3 bits, and an overflow bit marks 8.0 or more
module mcls_divider
   import mcls_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [MAG_W-1:0] numer,
   input  logic [MAG_W-1:0] denom,
   input  logic [3:0]       tag_in,
   output logic             out_valid,
   output logic [FRAC_BITS+2:0] quot,
   output logic             over,
   output logic [MAG_W-1:0] denom_out,
   output logic [3:0]       tag_out
);
   localparam int QW = FRAC_BITS + 3;
   localparam int NW = MAG_W + FRAC_BITS;
   localparam int RW = NW + 1;

   logic [QW:0]      valid_ff;
   logic [RW-1:0]    rem_ff  [QW+1];
   logic [MAG_W-1:0] den_ff  [QW+1];
   logic [QW-1:0]    q_ff    [QW+1];
   logic [3:0]       tag_ff  [QW+1];
   logic             ov_ff   [QW+1];

   // stage 0: overflow if numer*2^F >= 8*denom*2^F, i.e. numer >= 8*denom
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= QW; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= {1'b0, numer, {FRAC_BITS{1'b0}}};
         den_ff[0] <= denom;
         q_ff[0]   <= '0;
         tag_ff[0] <= tag_in;
         ov_ff[0]  <= ({3'b0, numer} >= {denom, 3'b0});
      end
   end

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [RW-1:0] shifted_d;
      logic          take;
      assign shifted_d = RW'({den_ff[s], {(QW-1-s){1'b0}}});
      assign take = rem_ff[s] >= shifted_d;
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s+1] <= take ? rem_ff[s] - shifted_d : rem_ff[s];
            q_ff[s+1]   <= {q_ff[s][QW-2:0], take};
            den_ff[s+1] <= den_ff[s];
            tag_ff[s+1] <= tag_ff[s];
            ov_ff[s+1]  <= ov_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign quot      = q_ff[QW];
   assign over      = ov_ff[QW];
   assign denom_out = den_ff[QW];
   assign tag_out   = tag_ff[QW];
endmodule

@@ tb/sv/tb_mc_limited_slope_top.sv @@
`timescale 1ns / 1ps

module tb_mc_limited_slope_top
   import mcls_pkg::*;
();

   localparam int RANDOM_PER_PHASE = 135;
   localparam int NUM_PHASES = 4;
   localparam int IDLE_LIMIT = 5000;
   localparam int PIPE_DRAIN = 40;
   localparam logic [17:0] PHI_ONE = 18'd65536;
   localparam logic [17:0] PHI_TWO = 18'd131072;
   localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S_MIN = 32'sh80000000;

   typedef struct packed {
      logic               vneg;
      logic signed [31:0] far;
      logic signed [31:0] behind;
      logic signed [31:0] centre;
      logic signed [31:0] ahead;
   } stencil_type;

   typedef struct packed {
      logic        clamped;
      logic [17:0] phi;
      logic [31:0] slope;
   } slope_type;

   typedef struct {
      stencil_type st;
      bit          typed;
      slope_type   res;
   } stim_row_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [31:0]  csr_data = '0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [55:0]  rsp_tdata;

   slope_type    pending_slopes[$];
   logic [31:0]  inv_width;
   int           errors = 0;
   int           requests_sent = 0;
   int           slopes_checked = 0;
   int           clamps_seen = 0;
   int           idle_cycles = 0;
   bit           hold_done = 0;
   stim_row_type directed[$];

   mc_limited_slope_top dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function automatic slope_type limit_slope(stencil_type s, logic [31:0] icw);
      longint d, n, r, phi;
      bit [63:0] dm, nm, q, t, hi, lo, mag;
      slope_type o;
      d = longint'(s.centre) - longint'(s.behind);
      n = s.vneg ? longint'(s.ahead) - longint'(s.centre)
                 : longint'(s.behind) - longint'(s.far);
      o.clamped = 0;
      dm = d < 0 ? -d : d;
      nm = n < 0 ? -n : n;
      if (d == 0) begin
         o.clamped = 1;
         r = n > 0 ? (4 <<< 16) : (n < 0 ? -(4 <<< 16) : 0);
      end else begin
         q = (nm << 16) / dm;
         if (q > (64'd4 << 16)) begin
            q = 64'd4 << 16;
            o.clamped = 1;
         end
         r = ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
      end
      phi = 0;
      if (r > 0) begin
         phi = (65536 + r) >>> 1;
         if (phi > 131072) phi = 131072;
         if (phi > 2 * r) phi = 2 * r;
      end
      t = (64'(phi) * dm) >> 16;
      hi = t * 64'(icw[31:16]);
      lo = t * 64'(icw[15:0]);
      if (hi >= (64'd1 << 47)) mag = 64'd1 << 40;
      else mag = ((hi << 16) + lo) >> 16;
      if (d < 0) begin
         if (mag > 64'h80000000) mag = 64'h80000000;
         o.slope = 32'(-mag);
      end else begin
         if (mag > 64'h7fffffff) mag = 64'h7fffffff;
         o.slope = mag[31:0];
      end
      o.phi = phi[17:0];
      return o;
   endfunction

   function automatic logic signed [31:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: return S_MAX;
         1: return S_MIN;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic stencil_type random_stencil();
      stencil_type s;
      logic signed [31:0] step;
      int kind;
      kind = $urandom_range(0, 9);
      s.vneg = $urandom_range(0, 1);
      s = {s.vneg, 32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
      if (kind <= 5) begin
         // smooth profile with jitter, the bulk of realistic grid data
         step = $urandom_range(0, 1 << $urandom_range(0, 20));
         if ($urandom_range(0, 1)) step = -step;
         s.behind = s.far + step + 32'($urandom_range(0, 1 << $urandom_range(0, 18)));
         s.centre = s.behind + step + 32'($urandom_range(0, 1 << $urandom_range(0, 18)));
         s.ahead = s.centre + step + 32'($urandom_range(0, 1 << $urandom_range(0, 18)));
      end else if (kind == 7) begin
         s.behind = s.centre;
         if ($urandom_range(0, 1)) s.far = s.behind;
      end else if (kind == 8) begin
         s.ahead = pick_extreme();
         s.centre = pick_extreme();
         s.behind = pick_extreme();
         s.far = pick_extreme();
      end
      return s;
   endfunction

   task automatic write_inv_width(logic [31:0] value);
      csr_valid <= 1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      inv_width = value;
   endtask

   // keeps tvalid high across back-to-back requests within a burst
   task automatic send_stencil(stencil_type s, bit keep_valid);
      req_tvalid <= 1;
      req_tdata <= {s.far, s.behind, s.centre, s.ahead};
      req_tuser <= s.vneg;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      if (!keep_valid) req_tvalid <= 0;
   endtask

   task automatic drain();
      while (pending_slopes.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic add_row(logic signed [31:0] a, c, b, f, logic v, bit typed,
                          logic [31:0] sl = 0, logic [17:0] ph = 0, logic cl = 0);
      stim_row_type row;
      row.st = {v, f, b, c, a};
      row.typed = typed;
      row.res = {cl, ph, sl};
      directed.push_back(row);
   endtask

   // receiver: random stall pattern, plus one long hold-off to back up the pipe
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!hold_done && requests_sent >= 60 && hold_left == 0) begin
            hold_left = 300;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else if ((requests_sent / 50) % 3 == 0) begin
            rsp_tready <= 1;
         end else begin
            rsp_tready <= $urandom_range(0, 3) != 0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         slope_type got, want;
         got = rsp_tdata[50:0];
         if (pending_slopes.size() == 0) begin
            $error("slope result with no request pending: %h", got);
            errors++;
         end else begin
            want = pending_slopes.pop_front();
            if (got.slope !== want.slope) begin
               $error("slope_value expected %h got %h", want.slope, got.slope);
               errors++;
            end
            if (got.phi !== want.phi) begin
               $error("limiter_value expected %h got %h", want.phi, got.phi);
               errors++;
            end
            if (got.clamped !== want.clamped) begin
               $error("ratio_clamped expected %b got %b", want.clamped, got.clamped);
               errors++;
            end
            if (rsp_tdata[55:51] !== '0) begin
               $error("rsp_tdata fill expected 0 got %h", rsp_tdata[55:51]);
               errors++;
            end
            if (want.clamped) clamps_seen++;
            slopes_checked++;
         end
      end
   end

   // predictions are queued on the same edge that accepts the request
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         pending_slopes.push_back(limit_slope(
            {req_tuser, req_tdata[127:96], req_tdata[95:64], req_tdata[63:32],
             req_tdata[31:0]}, inv_width));
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_mc_limited_slope_top NOT OK");
         $finish;
      end
   end

   initial begin
      logic [31:0] widths[NUM_PHASES];
      int burst;
      int gap;
      widths = '{INV_CELL_WIDTH_RESET, 32'hffffffff, 32'd1, 32'($urandom_range(1, 32'hffffffff))};
      inv_width = INV_CELL_WIDTH_RESET;

      add_row(0, 0, 0, 0, 0, 1, 0, 0, 1);
      add_row(0, 5 << 16, 5 << 16, 0, 0, 1, 0, PHI_TWO, 1);
      add_row(0, 5 << 16, 5 << 16, 10 << 16, 0, 1, 0, 0, 1);
      add_row(0, 5 << 16, 5 << 16, 0, 1, 1, 0, 0, 1);
      add_row(0, S_MAX, S_MIN, S_MAX, 0, 1, 0, 0, 0);
      add_row(0, S_MAX, S_MIN, S_MAX, 1, 1, 0, 0, 0);
      add_row(3 << 16, 2 << 16, 1 << 16, 0, 0, 1, 32'h10000, PHI_ONE, 0);
      add_row(3 << 16, 2 << 16, 1 << 16, 0, 1, 1, 32'h10000, PHI_ONE, 0);
      add_row(0, -(2 << 16), -(1 << 16), 0, 0, 1, 32'hffff0000, PHI_ONE, 0);
      add_row(S_MAX, S_MAX, 0, S_MIN, 0, 0);
      add_row(S_MIN, S_MIN, S_MAX, S_MIN, 1, 0);
      add_row(4, 1, 0, -3, 0, 0);
      add_row(5, 1, 0, -5, 1, 0);
      add_row(0, 2 << 16, 0, -(1 << 16), 0, 0);
      add_row(-1, -1, S_MIN, -1, 1, 0);
      add_row(S_MIN, S_MAX, -1, 0, 0, 0);
      add_row(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 1, 0);

      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_inv_width(widths[ph]);
         @(posedge clock);
         if (ph == 0) begin
            foreach (directed[i]) begin
               if (directed[i].typed &&
                   limit_slope(directed[i].st, inv_width) !== directed[i].res) begin
                  // the hand-typed value and the predictor must agree
                  $error("row %0d typed slope %h differs from predicted", i,
                         directed[i].res);
                  errors++;
               end
               // the random requests follow straight on
               send_stencil(directed[i].st, 1'b1);
            end
         end
         for (int k = 0; k < RANDOM_PER_PHASE; k += burst) begin
            burst = $urandom_range(1, 24);
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
            // the last burst of a phase drops tvalid before the drain
            if (k + burst >= RANDOM_PER_PHASE && gap == 0) gap = 1;
            for (int j = 0; j < burst; j++)
               send_stencil(random_stencil(), j != burst - 1 || gap == 0);
            repeat (gap) @(posedge clock);
         end
         drain();
      end

      $display("covered %0d stencils over %0d cell widths, %0d checked, %0d with clamped ratio",
               requests_sent, NUM_PHASES, slopes_checked, clamps_seen);
      $display("long receiver hold-off applied: %0d", hold_done);
      if (errors == 0 && pending_slopes.size() == 0)
         $display("tb_mc_limited_slope_top OK");
      else
         $display("tb_mc_limited_slope_top NOT OK");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/mcls_pkg.sv
rtl/mcls_divider.sv
rtl/mc_limited_slope_top.sv
tb/sv/tb_mc_limited_slope_top.sv
